@@ hw/rtl/ps2kbd_pkg.sv @@
package ps2kbd_pkg;

  localparam int unsigned PosWidth  = 16;
  localparam int unsigned CodeWidth = 8;
  localparam int unsigned GeoWidth  = 8;
  localparam int unsigned ModWidth  = 6;
  localparam int unsigned MapLen    = 58;

  localparam logic [CodeWidth-1:0] ScPrefixExt = 8'hE0;
  localparam logic [6:0] ScLshift = 7'h2A;
  localparam logic [6:0] ScRshift = 7'h36;
  localparam logic [6:0] ScDelete = 7'h53;
  localparam logic [6:0] ScCtrl   = 7'h1D;
  localparam logic [6:0] ScAlt    = 7'h38;
  localparam logic [6:0] ScLeft   = 7'd75;
  localparam logic [6:0] ScRight  = 7'd77;
  localparam logic [6:0] ScUp     = 7'd72;
  localparam logic [6:0] ScDown   = 7'd80;

  localparam int unsigned ModRshift = 0;
  localparam int unsigned ModLshift = 1;
  localparam int unsigned ModRctrl  = 2;
  localparam int unsigned ModLctrl  = 3;
  localparam int unsigned ModRalt   = 4;
  localparam int unsigned ModLalt   = 5;

  localparam logic [GeoWidth-1:0] RowsReset = 8'd25;
  localparam logic [GeoWidth-1:0] ColsReset = 8'd80;

  localparam logic [7:0] PlainMap [MapLen] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  localparam logic [7:0] ShiftMap [MapLen] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  typedef enum logic [0:0] {
    OP_SCAN = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    REG_SCREEN_ROWS = 1'b0,
    REG_SCREEN_COLS = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MV_LEFT,
    MV_RIGHT,
    MV_UP,
    MV_DOWN
  } move_e;

  typedef struct packed {
    op_e                 op;
    logic [CodeWidth-1:0] scan_code;
    logic [PosWidth-1:0]  read_pos;
    logic [PosWidth-1:0]  write_pos;
  } in_word_t;

  typedef struct packed {
    logic [CodeWidth-1:0] key_code;
    logic [PosWidth-1:0]  cursor_pos;
    logic                 cursor_update;
    logic                 reset_request;
  } out_word_t;

  typedef struct packed {
    cfg_reg_e            index;
    logic [GeoWidth-1:0] data;
  } cfg_word_t;

  typedef struct packed {
    logic [CodeWidth-1:0] key_code;
    logic                 reset_request;
    logic                 arrow;
    move_e                move;
    logic [PosWidth-1:0]  rpos;
    logic [PosWidth-1:0]  wpos;
    logic [PosWidth-1:0]  cells;
  } ctx_t;

  typedef struct packed {
    ctx_t                ctx;
    logic [PosWidth-1:0] rem;
    logic [PosWidth-1:0] dividend;
  } mod_word_t;

  function automatic logic [7:0] ascii_map(input logic [5:0] code, input logic shifted);
    logic [7:0] val;
    val = 8'h00;
    if (32'(code) < MapLen) begin
      val = shifted ? ShiftMap[code] : PlainMap[code];
    end
    return val;
  endfunction

endpackage

@@ hw/rtl/ps2kbd_chan_if.sv @@
interface ps2kbd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/ps2kbd_mod_stage.sv @@
module ps2kbd_mod_stage #(
  parameter int unsigned BitsPerStage = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  ps2kbd_pkg::mod_word_t data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output ps2kbd_pkg::mod_word_t data_o
);

  localparam int unsigned W = ps2kbd_pkg::PosWidth;

  logic                  valid_q;
  ps2kbd_pkg::mod_word_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // shift-subtract remainder, BitsPerStage dividend bits per stage
  always_comb begin
    logic [W-1:0] rem;
    logic [W-1:0] div;
    logic [W:0]   trial;
    rem = data_i.rem;
    div = data_i.dividend;
    for (int i = 0; i < BitsPerStage; i++) begin
      trial = {rem, div[W-1]};
      div   = {div[W-2:0], 1'b0};
      if (trial >= {1'b0, data_i.ctx.cells}) begin
        trial = trial - {1'b0, data_i.ctx.cells};
      end
      rem = trial[W-1:0];
    end
    data_d          = data_i;
    data_d.rem      = rem;
    data_d.dividend = div;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

@@ hw/rtl/ps2_scancode_keyboard_decoder_unit.sv @@
// Scan code set 1 keyboard decoder. Takes one word per cycle on in_i unless stalled (a scan
// code byte or a read of the one-key latch) and returns exactly one result word per input
// word, in order, on out_o. Modifier, prefix and latch state change as each word leaves the
// input register, so reads see every earlier key. The cursor wrap needs write_pos modulo
// rows*cols, done by a shift-subtract remainder pipeline of 16/ModBitsPerStage stages;
// throughput one word per cycle when no stage stalls. Every stage has its own valid and stalls
// only when the stage after it is full.
// Geometry registers are written on cfg_i (index 0 rows, 1 cols) and must not change while
// words are in flight.
module ps2_scancode_keyboard_decoder_unit #(
  parameter int unsigned ModBitsPerStage = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ps2kbd_chan_if.sink   in_i,
  ps2kbd_chan_if.source out_o,
  ps2kbd_chan_if.sink   cfg_i
);

  localparam int unsigned W = ps2kbd_pkg::PosWidth;
  localparam int unsigned NumModStages = W / ModBitsPerStage;

  logic [ps2kbd_pkg::GeoWidth-1:0] rows_q, cols_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ps2kbd_pkg::RowsReset;
      cols_q <= ps2kbd_pkg::ColsReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        ps2kbd_pkg::REG_SCREEN_ROWS: rows_q <= cfg_i.payload.data;
        ps2kbd_pkg::REG_SCREEN_COLS: cols_q <= cfg_i.payload.data;
        default: ;
      endcase
    end
  end

  // input register
  logic                 v0_q;
  ps2kbd_pkg::in_word_t w0_q;
  logic                 rdy1;
  logic                 fire0;

  assign in_i.ready = !v0_q || rdy1;
  assign fire0      = v0_q && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (in_i.ready) begin
      v0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      w0_q <= in_i.payload;
    end
  end

  // decode and key state
  logic [ps2kbd_pkg::ModWidth-1:0]  mod_q, mod_d;
  logic                             ext_q, ext_d;
  logic [ps2kbd_pkg::CodeWidth-1:0] latch_q, latch_d;
  ps2kbd_pkg::ctx_t                 ctx;
  logic                             shifted, ctrl_held, alt_held;

  always_comb begin
    mod_d     = mod_q;
    ext_d     = ext_q;
    latch_d   = latch_q;
    shifted   = mod_q[ps2kbd_pkg::ModLshift] | mod_q[ps2kbd_pkg::ModRshift];
    ctrl_held = mod_q[ps2kbd_pkg::ModLctrl] | mod_q[ps2kbd_pkg::ModRctrl];
    alt_held  = mod_q[ps2kbd_pkg::ModLalt] | mod_q[ps2kbd_pkg::ModRalt];
    ctx       = '0;
    ctx.move  = ps2kbd_pkg::MV_LEFT;
    ctx.rpos  = w0_q.read_pos;
    ctx.wpos  = w0_q.write_pos;
    ctx.cells = W'(16'(rows_q) * 16'(cols_q));
    if (w0_q.op == ps2kbd_pkg::OP_READ) begin
      ctx.key_code = latch_q;
      latch_d      = '0;
    end else if (w0_q.scan_code == ps2kbd_pkg::ScPrefixExt) begin
      ext_d = 1'b1;
    end else if (ext_q) begin
      ext_d = 1'b0;
      if (!w0_q.scan_code[7]) begin
        case (w0_q.scan_code[6:0])
          ps2kbd_pkg::ScAlt: mod_d[ps2kbd_pkg::ModRalt] = 1'b1;
          ps2kbd_pkg::ScCtrl: mod_d[ps2kbd_pkg::ModRctrl] = 1'b1;
          ps2kbd_pkg::ScDelete: ctx.reset_request = ctrl_held & alt_held;
          ps2kbd_pkg::ScLeft: begin
            ctx.arrow = 1'b1;
            ctx.move  = ps2kbd_pkg::MV_LEFT;
          end
          ps2kbd_pkg::ScRight: begin
            ctx.arrow = 1'b1;
            ctx.move  = ps2kbd_pkg::MV_RIGHT;
          end
          ps2kbd_pkg::ScUp: begin
            ctx.arrow = 1'b1;
            ctx.move  = ps2kbd_pkg::MV_UP;
          end
          ps2kbd_pkg::ScDown: begin
            ctx.arrow = 1'b1;
            ctx.move  = ps2kbd_pkg::MV_DOWN;
          end
          default: ;
        endcase
      end else begin
        case (w0_q.scan_code[6:0])
          ps2kbd_pkg::ScAlt: mod_d[ps2kbd_pkg::ModRalt] = 1'b0;
          ps2kbd_pkg::ScCtrl: mod_d[ps2kbd_pkg::ModRctrl] = 1'b0;
          default: ;
        endcase
      end
    end else if (!w0_q.scan_code[7]) begin
      case (w0_q.scan_code[6:0])
        ps2kbd_pkg::ScLshift: mod_d[ps2kbd_pkg::ModLshift] = 1'b1;
        ps2kbd_pkg::ScRshift: mod_d[ps2kbd_pkg::ModRshift] = 1'b1;
        ps2kbd_pkg::ScAlt: mod_d[ps2kbd_pkg::ModLalt] = 1'b1;
        ps2kbd_pkg::ScCtrl: mod_d[ps2kbd_pkg::ModLctrl] = 1'b1;
        default: begin
          if (latch_q == '0) begin
            if (32'(w0_q.scan_code) >= ps2kbd_pkg::MapLen) begin
              latch_d = w0_q.scan_code;
            end else begin
              latch_d = ps2kbd_pkg::ascii_map(w0_q.scan_code[5:0], shifted);
            end
          end
        end
      endcase
    end else begin
      case (w0_q.scan_code[6:0])
        ps2kbd_pkg::ScLshift: mod_d[ps2kbd_pkg::ModLshift] = 1'b0;
        ps2kbd_pkg::ScRshift: mod_d[ps2kbd_pkg::ModRshift] = 1'b0;
        ps2kbd_pkg::ScAlt: mod_d[ps2kbd_pkg::ModLalt] = 1'b0;
        ps2kbd_pkg::ScCtrl: mod_d[ps2kbd_pkg::ModLctrl] = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q   <= '0;
      ext_q   <= 1'b0;
      latch_q <= '0;
    end else if (fire0) begin
      mod_q   <= mod_d;
      ext_q   <= ext_d;
      latch_q <= latch_d;
    end
  end

  // remainder pipeline: write_pos mod cells
  logic                  sv_valid [NumModStages+1];
  logic                  sv_ready [NumModStages+1];
  ps2kbd_pkg::mod_word_t sv_data  [NumModStages+1];
  logic                  rdy_f;

  assign sv_valid[0]         = v0_q;
  assign rdy1                = sv_ready[0];
  assign sv_data[0].ctx      = ctx;
  assign sv_data[0].rem      = '0;
  assign sv_data[0].dividend = w0_q.write_pos;
  assign sv_ready[NumModStages] = rdy_f;

  for (genvar g = 0; g < NumModStages; g++) begin : g_mod
    ps2kbd_mod_stage #(
      .BitsPerStage(ModBitsPerStage)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sv_valid[g]),
      .ready_o(sv_ready[g]),
      .data_i (sv_data[g]),
      .valid_o(sv_valid[g+1]),
      .ready_i(sv_ready[g+1]),
      .data_o (sv_data[g+1])
    );
  end

  // wrap stage
  ps2kbd_pkg::ctx_t fctx;
  logic [W-1:0]     rem, cells, dm, dz, wrap;
  logic [W:0]       diff, sum;
  logic             horiz, neg;
  logic             vf_q;
  ps2kbd_pkg::ctx_t ctx_f_q;
  logic [W-1:0]     wrap_f_q;
  logic             rdy_out;

  always_comb begin
    fctx  = sv_data[NumModStages].ctx;
    rem   = sv_data[NumModStages].rem;
    cells = fctx.cells;
    horiz = (fctx.move == ps2kbd_pkg::MV_LEFT) || (fctx.move == ps2kbd_pkg::MV_RIGHT);
    neg   = (fctx.move == ps2kbd_pkg::MV_LEFT) || (fctx.move == ps2kbd_pkg::MV_UP);
    dz    = horiz ? W'(1) : W'(cols_q);
    if (horiz) begin
      dm = (cells == W'(1)) ? '0 : W'(1);
    end else begin
      dm = (rows_q == 8'd1) ? '0 : W'(cols_q);
    end
    diff = {1'b0, rem} - {1'b0, dm};
    sum  = {1'b0, rem} + {1'b0, dm};
    if (cells == '0) begin
      wrap = neg ? (fctx.wpos - dz) : (fctx.wpos + dz);
    end else if (neg) begin
      wrap = diff[W] ? (diff[W-1:0] + cells) : diff[W-1:0];
    end else begin
      wrap = (sum >= {1'b0, cells}) ? W'(sum - {1'b0, cells}) : sum[W-1:0];
    end
  end

  assign rdy_f = !vf_q || rdy_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (rdy_f) begin
      vf_q <= sv_valid[NumModStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_valid[NumModStages] && rdy_f) begin
      ctx_f_q  <= fctx;
      wrap_f_q <= wrap;
    end
  end

  // output register
  logic                  vo_q;
  ps2kbd_pkg::out_word_t wo_q, wo_d;

  assign rdy_out       = !vo_q || out_o.ready;
  assign out_o.valid   = vo_q;
  assign out_o.payload = wo_q;

  always_comb begin
    wo_d.key_code      = ctx_f_q.key_code;
    wo_d.reset_request = ctx_f_q.reset_request;
    wo_d.cursor_update = ctx_f_q.arrow;
    if (!ctx_f_q.arrow) begin
      wo_d.cursor_pos = '0;
    end else if (wrap_f_q > ctx_f_q.rpos) begin
      wo_d.cursor_pos = wrap_f_q;
    end else begin
      wo_d.cursor_pos = ctx_f_q.rpos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (rdy_out) begin
      vo_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vf_q && rdy_out) begin
      wo_q <= wo_d;
    end
  end

endmodule

@@ hw/rtl/ps2kbd_checker.sv @@
module ps2kbd_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input ps2kbd_pkg::out_word_t out_word_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_word_i))
    else $error("result word changed while stalled");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with output empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_word_i.cursor_update |-> out_word_i.cursor_pos == '0)
    else $error("cursor position without update");

  // a word is at most one of a read, a cursor move or a reset request, never two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_word_i.cursor_update && out_word_i.reset_request) &&
                    (out_word_i.key_code == '0 ||
                     (!out_word_i.cursor_update && !out_word_i.reset_request)))
    else $error("result word mixes kinds");

endmodule

bind ps2_scancode_keyboard_decoder_unit ps2kbd_checker u_ps2kbd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_word_i (out_o.payload)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

class ps2_decode_sb;
  logic [ps2kbd_pkg::GeoWidth-1:0]  rows;
  logic [ps2kbd_pkg::GeoWidth-1:0]  cols;
  logic [ps2kbd_pkg::ModWidth-1:0]  mods;
  logic                             ext_pending;
  logic [ps2kbd_pkg::CodeWidth-1:0] held_key;
  ps2kbd_pkg::out_word_t            decoded_q[$];
  int                               mismatches;

  function new();
    rows        = ps2kbd_pkg::RowsReset;
    cols        = ps2kbd_pkg::ColsReset;
    mods        = '0;
    ext_pending = 1'b0;
    held_key    = '0;
    mismatches  = 0;
  endfunction

  function void set_reg(ps2kbd_pkg::cfg_reg_e idx, logic [ps2kbd_pkg::GeoWidth-1:0] val);
    if (idx == ps2kbd_pkg::REG_SCREEN_ROWS) begin
      rows = val;
    end else begin
      cols = val;
    end
  endfunction

  function logic [ps2kbd_pkg::PosWidth-1:0] cursor_after(
      logic [ps2kbd_pkg::PosWidth-1:0] wpos, logic [ps2kbd_pkg::PosWidth-1:0] rpos,
      int step);
    int cells;
    int v;
    int m;
    cells = int'(rows) * int'(cols);
    v = int'(wpos) + step;
    if (cells == 0) begin
      m = v & 32'hffff;
    end else begin
      m = v % cells;
      if (m < 0) m += cells;
    end
    return (m > int'(rpos)) ? m[15:0] : rpos;
  endfunction

  function void decode_word(ps2kbd_pkg::in_word_t w);
    ps2kbd_pkg::out_word_t r;
    logic [6:0] low;
    r = '0;
    low = w.scan_code[6:0];
    if (w.op == ps2kbd_pkg::OP_READ) begin
      r.key_code = held_key;
      held_key = '0;
    end else if (w.scan_code == ps2kbd_pkg::ScPrefixExt) begin
      ext_pending = 1'b1;
    end else if (ext_pending) begin
      ext_pending = 1'b0;
      if (!w.scan_code[7]) begin
        case (low)
          ps2kbd_pkg::ScAlt: mods[ps2kbd_pkg::ModRalt] = 1'b1;
          ps2kbd_pkg::ScCtrl: mods[ps2kbd_pkg::ModRctrl] = 1'b1;
          ps2kbd_pkg::ScDelete: begin
            r.reset_request = (mods[ps2kbd_pkg::ModLctrl] | mods[ps2kbd_pkg::ModRctrl]) &
                              (mods[ps2kbd_pkg::ModLalt] | mods[ps2kbd_pkg::ModRalt]);
          end
          ps2kbd_pkg::ScLeft: begin
            r.cursor_pos = cursor_after(w.write_pos, w.read_pos, -1);
            r.cursor_update = 1'b1;
          end
          ps2kbd_pkg::ScRight: begin
            r.cursor_pos = cursor_after(w.write_pos, w.read_pos, 1);
            r.cursor_update = 1'b1;
          end
          ps2kbd_pkg::ScUp: begin
            r.cursor_pos = cursor_after(w.write_pos, w.read_pos, -int'(cols));
            r.cursor_update = 1'b1;
          end
          ps2kbd_pkg::ScDown: begin
            r.cursor_pos = cursor_after(w.write_pos, w.read_pos, int'(cols));
            r.cursor_update = 1'b1;
          end
          default: ;
        endcase
      end else if (low == ps2kbd_pkg::ScAlt) begin
        mods[ps2kbd_pkg::ModRalt] = 1'b0;
      end else if (low == ps2kbd_pkg::ScCtrl) begin
        mods[ps2kbd_pkg::ModRctrl] = 1'b0;
      end
    end else if (!w.scan_code[7]) begin
      case (low)
        ps2kbd_pkg::ScLshift: mods[ps2kbd_pkg::ModLshift] = 1'b1;
        ps2kbd_pkg::ScRshift: mods[ps2kbd_pkg::ModRshift] = 1'b1;
        ps2kbd_pkg::ScAlt: mods[ps2kbd_pkg::ModLalt] = 1'b1;
        ps2kbd_pkg::ScCtrl: mods[ps2kbd_pkg::ModLctrl] = 1'b1;
        default: begin
          if (held_key == '0) begin
            if (low >= ps2kbd_pkg::MapLen) begin
              held_key = w.scan_code;
            end else if (mods[ps2kbd_pkg::ModLshift] | mods[ps2kbd_pkg::ModRshift]) begin
              held_key = ps2kbd_pkg::ShiftMap[low];
            end else begin
              held_key = ps2kbd_pkg::PlainMap[low];
            end
          end
        end
      endcase
    end else begin
      case (low)
        ps2kbd_pkg::ScLshift: mods[ps2kbd_pkg::ModLshift] = 1'b0;
        ps2kbd_pkg::ScRshift: mods[ps2kbd_pkg::ModRshift] = 1'b0;
        ps2kbd_pkg::ScAlt: mods[ps2kbd_pkg::ModLalt] = 1'b0;
        ps2kbd_pkg::ScCtrl: mods[ps2kbd_pkg::ModLctrl] = 1'b0;
        default: ;
      endcase
    end
    decoded_q.push_back(r);
  endfunction

  function void check_word(ps2kbd_pkg::out_word_t got);
    ps2kbd_pkg::out_word_t want;
    if (decoded_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word %h", got);
      return;
    end
    want = decoded_q.pop_front();
    if (got.key_code !== want.key_code || got.cursor_pos !== want.cursor_pos ||
        got.cursor_update !== want.cursor_update ||
        got.reset_request !== want.reset_request) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch key %h/%h cursor %h/%h update %b/%b reset %b/%b (exp/act)",
                 want.key_code, got.key_code, want.cursor_pos, got.cursor_pos,
                 want.cursor_update, got.cursor_update,
                 want.reset_request, got.reset_request);
      end
    end
  endfunction
endclass

module tb;
  localparam int QuietLimit = 4000;

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_stall_pct;
  int   quiet_cycles;

  ps2_decode_sb board;

  ps2kbd_chan_if #(.payload_t(ps2kbd_pkg::in_word_t))  in_if ();
  ps2kbd_chan_if #(.payload_t(ps2kbd_pkg::out_word_t)) out_if ();
  ps2kbd_chan_if #(.payload_t(ps2kbd_pkg::cfg_word_t)) cfg_if ();

  ps2_scancode_keyboard_decoder_unit i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic ps2kbd_pkg::in_word_t word_of(ps2kbd_pkg::op_e op, logic [7:0] code,
                                                   logic [15:0] rpos, logic [15:0] wpos);
    ps2kbd_pkg::in_word_t w;
    w.op = op;
    w.scan_code = code;
    w.read_pos = rpos;
    w.write_pos = wpos;
    return w;
  endfunction

  function automatic int cell_span();
    int cells;
    cells = int'(board.rows) * int'(board.cols);
    if (cells == 0) cells = 65536;
    return cells;
  endfunction

  function automatic logic [15:0] rand_wpos();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, cell_span() - 1));
  endfunction

  function automatic logic [15:0] rand_rpos();
    int pick;
    pick = $urandom_range(0, 3);
    if (pick < 2) return 16'h0000;
    if (pick == 2) return 16'($urandom_range(0, cell_span() - 1));
    return 16'($urandom);
  endfunction

  function automatic ps2kbd_pkg::in_word_t scan_word(logic [7:0] code);
    return word_of(ps2kbd_pkg::OP_SCAN, code, rand_rpos(), rand_wpos());
  endfunction

  task automatic push_word(ps2kbd_pkg::in_word_t w);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= w;
    do @(posedge clk); while (!in_if.ready);
    board.decode_word(w);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (board.decoded_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(ps2kbd_pkg::cfg_reg_e idx, logic [7:0] val);
    ps2kbd_pkg::cfg_word_t c;
    c.index = idx;
    c.data = val;
    cfg_if.valid <= 1'b1;
    cfg_if.payload <= c;
    do @(posedge clk); while (!cfg_if.ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_traffic(int n);
    int sent;
    int kind;
    logic [6:0] k;
    logic [6:0] arrows [4];
    logic [6:0] mod_codes [4];
    arrows = '{ps2kbd_pkg::ScLeft, ps2kbd_pkg::ScRight, ps2kbd_pkg::ScUp, ps2kbd_pkg::ScDown};
    mod_codes = '{ps2kbd_pkg::ScLshift, ps2kbd_pkg::ScRshift, ps2kbd_pkg::ScCtrl,
                  ps2kbd_pkg::ScAlt};
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) == 0) wait_idle();
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        k = 7'($urandom_range(0, 127));
        push_word(scan_word({1'b0, k}));
        sent++;
        if ($urandom_range(0, 1) == 1) begin
          push_word(scan_word({1'b1, k}));
          sent++;
        end
      end else if (kind < 50) begin
        push_word(word_of(ps2kbd_pkg::OP_READ, 8'($urandom), rand_rpos(), rand_wpos()));
        sent++;
      end else if (kind < 62) begin
        k = mod_codes[$urandom_range(0, 3)];
        if ($urandom_range(0, 2) == 0) begin
          push_word(scan_word(ps2kbd_pkg::ScPrefixExt));
          sent++;
        end
        push_word(scan_word({1'($urandom_range(0, 1)), k}));
        sent++;
      end else if (kind < 82) begin
        push_word(scan_word(ps2kbd_pkg::ScPrefixExt));
        push_word(scan_word({1'b0, arrows[$urandom_range(0, 3)]}));
        sent += 2;
      end else if (kind < 88) begin
        // maybe ctrl, maybe alt, extended delete, then maybe let go
        if ($urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 1) == 1) begin
            push_word(scan_word(ps2kbd_pkg::ScPrefixExt));
            sent++;
          end
          push_word(scan_word({1'b0, ps2kbd_pkg::ScCtrl}));
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 1) == 1) begin
            push_word(scan_word(ps2kbd_pkg::ScPrefixExt));
            sent++;
          end
          push_word(scan_word({1'b0, ps2kbd_pkg::ScAlt}));
          sent++;
        end
        push_word(scan_word(ps2kbd_pkg::ScPrefixExt));
        push_word(scan_word({1'b0, ps2kbd_pkg::ScDelete}));
        sent += 2;
        if ($urandom_range(0, 1) == 1) begin
          push_word(scan_word({1'b1, ps2kbd_pkg::ScCtrl}));
          push_word(scan_word({1'b1, ps2kbd_pkg::ScAlt}));
          sent += 2;
        end
      end else if (kind < 94) begin
        push_word(scan_word(ps2kbd_pkg::ScPrefixExt));
        push_word(scan_word(8'($urandom)));
        sent += 2;
      end else begin
        push_word(scan_word(8'($urandom)));
        sent++;
      end
    end
  endtask

  task automatic run_phase(logic [7:0] r, logic [7:0] c, int idle_in, int stall_out, int n);
    wait_idle();
    write_reg(ps2kbd_pkg::REG_SCREEN_ROWS, r);
    write_reg(ps2kbd_pkg::REG_SCREEN_COLS, c);
    in_idle_pct = idle_in;
    out_stall_pct = stall_out;
    random_traffic(n);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) board.check_word(out_if.payload);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    board = new();
    quiet_cycles = 0;
    in_idle_pct = 25;
    out_stall_pct = 51;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    out_if.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset geometry 25 x 80
    push_word(word_of(ps2kbd_pkg::OP_READ, 8'hFF, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, 8'h1E, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, 8'h30, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_READ, 8'h00, 16'hFFFF, 16'hFFFF));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, {1'b0, ps2kbd_pkg::ScLshift}, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, 8'h02, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, {1'b1, ps2kbd_pkg::ScLshift}, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_READ, 8'h00, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, 8'h7F, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_READ, 8'h00, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, 8'h00, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_READ, 8'h00, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, 8'h9E, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, ps2kbd_pkg::ScPrefixExt, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, ps2kbd_pkg::ScPrefixExt, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, {1'b0, ps2kbd_pkg::ScLeft}, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, ps2kbd_pkg::ScPrefixExt, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, {1'b0, ps2kbd_pkg::ScUp}, 16'hFFFF, 16'hFFFF));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, ps2kbd_pkg::ScPrefixExt, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, {1'b0, ps2kbd_pkg::ScDown}, 16'h0000, 16'd1999));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, ps2kbd_pkg::ScPrefixExt, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, {1'b0, ps2kbd_pkg::ScRight}, 16'h0000, 16'd1999));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, {1'b0, ps2kbd_pkg::ScCtrl}, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, ps2kbd_pkg::ScPrefixExt, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, {1'b0, ps2kbd_pkg::ScAlt}, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, ps2kbd_pkg::ScPrefixExt, 16'h0000, 16'h0000));
    push_word(word_of(ps2kbd_pkg::OP_SCAN, {1'b0, ps2kbd_pkg::ScDelete}, 16'h0000, 16'h0000));

    run_phase(8'd255, 8'd255, 25, 51, 240);
    run_phase(8'd1, 8'd1, 51, 25, 240);
    // zero geometry falls back to plain 16-bit wrap
    run_phase(8'd0, 8'($urandom_range(1, 255)), 51, 25, 30);
    run_phase(8'($urandom_range(2, 40)), 8'($urandom_range(2, 60)), 0, 0, 240);

    wait_idle();
    repeat (20) @(negedge clk);
    if (board.mismatches == 0 && board.decoded_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/ps2kbd_pkg.sv
hw/rtl/ps2kbd_chan_if.sv
hw/rtl/ps2kbd_mod_stage.sv
hw/rtl/ps2_scancode_keyboard_decoder_unit.sv
hw/rtl/ps2kbd_checker.sv
dv/tb.sv
